/* design/pmp_pkg.sv */
package pmp_pkg;

   // Field widths of the channels.
   localparam int unsigned FIELD_W = 32;
   localparam int unsigned LANE_W = 3;
   localparam int unsigned CSR_INDEX_W = 3;

   // Internal arithmetic widths.
   localparam int unsigned OPND_W = 34;   // clamped projection, Q16.16 plus sign
   localparam int unsigned PROD_W = 66;   // one product of the shared multiplier
   localparam int unsigned ACC_W = 67;    // sum of three dot-product terms
   localparam int unsigned DIST_W = 37;   // distance or projection, Q16.16
   localparam int unsigned DIFF_W = 38;   // coordinate minus correction term

   // Bit positions inside mirror_flags.
   localparam int unsigned FLAG_INSIDE_OUT = 0;
   localparam int unsigned FLAG_FORCE = 1;
   localparam logic [1:0] FLAGS_RESET = 2'b10;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_NORMAL_X = 3'd0,
      CFG_NORMAL_Y = 3'd1,
      CFG_NORMAL_Z = 3'd2,
      CFG_PLANE_OFFSET = 3'd3,
      CFG_MARGIN = 3'd4,
      CFG_FLAGS = 3'd5,
      CFG_VERTEX_BASE = 3'd6,
      CFG_CELL_BASE = 3'd7
   } cfg_index_type;

   // One input item.
   typedef struct packed {
      logic signed [FIELD_W-1:0] point_x;
      logic signed [FIELD_W-1:0] point_y;
      logic signed [FIELD_W-1:0] point_z;
      logic signed [FIELD_W-1:0] field_vec_x;
      logic signed [FIELD_W-1:0] field_vec_y;
      logic signed [FIELD_W-1:0] field_vec_z;
      logic signed [FIELD_W-1:0] field_scalar;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [FIELD_W-1:0] mirror_x;
      logic signed [FIELD_W-1:0] mirror_y;
      logic signed [FIELD_W-1:0] mirror_z;
      logic signed [FIELD_W-1:0] mirror_vec_x;
      logic signed [FIELD_W-1:0] mirror_vec_y;
      logic signed [FIELD_W-1:0] mirror_vec_z;
      logic signed [FIELD_W-1:0] mirror_scalar;
      logic [FIELD_W-1:0] new_vertex_label;
      logic [FIELD_W-1:0] new_cell_label;
   } rsp_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOT_P,
      ST_SUM_P,
      ST_RAW,
      ST_JUDGE,
      ST_DOT_V,
      ST_SUM_V,
      ST_PROJ,
      ST_CORR,
      ST_RESULT
   } state_type;

   // Operand source of the shared multiplier.
   typedef enum logic [1:0] {
      SRC_POINT,
      SRC_VEC,
      SRC_CORR
   } mul_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      mul_src_type mul_src;
      logic [LANE_W-1:0] mul_lane;
      logic acc_clr;
      logic acc_add;
      logic raw_save;
      logic kp_save;
      logic kv_save;
      logic res_wr;
      logic [LANE_W-1:0] res_lane;
      logic count_inc;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mirror_ok;
   } status_type;

   // Limit a distance to +-(2^33 - 1) before it scales the normal.
   function automatic logic signed [OPND_W-1:0] clamp33(input logic signed [DIST_W-1:0] k);
      logic signed [DIST_W-1:0] lim;
      lim = DIST_W'(37'sh1_FFFF_FFFF);
      if (k > lim) begin
         return OPND_W'(lim);
      end else if (k < -lim) begin
         return OPND_W'(-lim);
      end
      return OPND_W'(k);
   endfunction

   // Saturate to the signed 32-bit range.
   function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [DIFF_W-1:0] r);
      if (r > DIFF_W'(38'sh0_7FFF_FFFF)) begin
         return 32'sh7FFF_FFFF;
      end else if (r < -DIFF_W'(38'sh0_8000_0000)) begin
         return 32'sh8000_0000;
      end
      return FIELD_W'(r);
   endfunction

endpackage

/* design/pmp_ctrl.sv */
module pmp_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  pmp_pkg::status_type status,
   output pmp_pkg::cmd_type cmd
);

   pmp_pkg::state_type state_ff, state_in;
   logic [pmp_pkg::LANE_W-1:0] step_ff, step_in;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmp_pkg::ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   // Next state: the step counter restarts whenever the state changes.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pmp_pkg::ST_IDLE: begin
            if (req_valid) state_in = pmp_pkg::ST_DOT_P;
         end
         pmp_pkg::ST_DOT_P: begin
            if (step_ff == 3'd2) state_in = pmp_pkg::ST_SUM_P;
         end
         pmp_pkg::ST_SUM_P: state_in = pmp_pkg::ST_RAW;
         pmp_pkg::ST_RAW: state_in = pmp_pkg::ST_JUDGE;
         pmp_pkg::ST_JUDGE: begin
            state_in = status.mirror_ok ? pmp_pkg::ST_DOT_V : pmp_pkg::ST_IDLE;
         end
         pmp_pkg::ST_DOT_V: begin
            if (step_ff == 3'd2) state_in = pmp_pkg::ST_SUM_V;
         end
         pmp_pkg::ST_SUM_V: state_in = pmp_pkg::ST_PROJ;
         pmp_pkg::ST_PROJ: state_in = pmp_pkg::ST_CORR;
         pmp_pkg::ST_CORR: begin
            if (step_ff == 3'd6) state_in = pmp_pkg::ST_RESULT;
         end
         pmp_pkg::ST_RESULT: begin
            if (!rsp_stall) state_in = pmp_pkg::ST_IDLE;
         end
         default: state_in = pmp_pkg::ST_IDLE;
      endcase
      step_in = (state_in != state_ff) ? '0 : step_ff + 3'd1;
   end

   // Commands for the datapath in each state.
   always_comb begin
      cmd = '0;
      cmd.mul_src = pmp_pkg::SRC_POINT;
      req_stall = (state_ff != pmp_pkg::ST_IDLE);
      rsp_valid = (state_ff == pmp_pkg::ST_RESULT);
      unique case (state_ff)
         pmp_pkg::ST_IDLE: cmd.load = req_valid;
         pmp_pkg::ST_DOT_P: begin
            cmd.mul_src = pmp_pkg::SRC_POINT;
            cmd.mul_lane = step_ff;
            cmd.acc_clr = (step_ff == 3'd0);
            cmd.acc_add = (step_ff != 3'd0);
         end
         pmp_pkg::ST_SUM_P: cmd.acc_add = 1'b1;
         pmp_pkg::ST_RAW: cmd.raw_save = 1'b1;
         pmp_pkg::ST_JUDGE: cmd.kp_save = 1'b1;
         pmp_pkg::ST_DOT_V: begin
            cmd.mul_src = pmp_pkg::SRC_VEC;
            cmd.mul_lane = step_ff;
            cmd.acc_clr = (step_ff == 3'd0);
            cmd.acc_add = (step_ff != 3'd0);
         end
         pmp_pkg::ST_SUM_V: cmd.acc_add = 1'b1;
         pmp_pkg::ST_PROJ: cmd.kv_save = 1'b1;
         pmp_pkg::ST_CORR: begin
            // Lane n is multiplied at step n and written back at step n+1.
            cmd.mul_src = pmp_pkg::SRC_CORR;
            cmd.mul_lane = step_ff;
            cmd.res_wr = (step_ff != 3'd0);
            cmd.res_lane = step_ff - 3'd1;
         end
         pmp_pkg::ST_RESULT: cmd.count_inc = !rsp_stall;
         default: cmd = '0;
      endcase
   end

endmodule

/* design/pmp_datapath.sv */
module pmp_datapath (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [pmp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pmp_pkg::FIELD_W-1:0] csr_data,
   input  pmp_pkg::req_type req_payload,
   output pmp_pkg::rsp_type rsp_payload,
   input  pmp_pkg::cmd_type cmd,
   output pmp_pkg::status_type status
);

   localparam int unsigned FW = pmp_pkg::FIELD_W;

   // Configuration registers.
   logic signed [FW-1:0] normal_x_ff, normal_y_ff, normal_z_ff, plane_offset_ff;
   logic [FW-2:0] margin_ff;
   logic [1:0] flags_ff;
   logic [FW-1:0] vertex_base_ff, cell_base_ff;
   logic [FW-1:0] count_ff;

   // Working registers for one item.
   pmp_pkg::req_type item_ff;
   logic signed [pmp_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [pmp_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [pmp_pkg::DIST_W-1:0] raw_ff, raw_in;
   logic signed [pmp_pkg::OPND_W-1:0] kp_ff, kv_ff;
   pmp_pkg::rsp_type res_ff;

   logic signed [pmp_pkg::OPND_W-1:0] mul_a;
   logic signed [FW-1:0] mul_b;
   logic signed [pmp_pkg::PROD_W-1:0] rnd;
   logic signed [pmp_pkg::DIST_W-1:0] acc_q16;
   logic signed [FW-1:0] q_sel;
   logic signed [pmp_pkg::DIFF_W-1:0] diff;
   logic signed [FW-1:0] res_val;
   logic signed [pmp_pkg::DIFF_W-1:0] raw_ext, margin_ext, judge_sum, judge_diff;
   logic normal_zero, beyond;

   // Configuration writes and the running count of mirrored items.
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_x_ff <= '0;
         normal_y_ff <= '0;
         normal_z_ff <= '0;
         plane_offset_ff <= '0;
         margin_ff <= '0;
         flags_ff <= pmp_pkg::FLAGS_RESET;
         vertex_base_ff <= '0;
         cell_base_ff <= '0;
         count_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               pmp_pkg::CFG_NORMAL_X: normal_x_ff <= csr_data;
               pmp_pkg::CFG_NORMAL_Y: normal_y_ff <= csr_data;
               pmp_pkg::CFG_NORMAL_Z: normal_z_ff <= csr_data;
               pmp_pkg::CFG_PLANE_OFFSET: plane_offset_ff <= csr_data;
               pmp_pkg::CFG_MARGIN: margin_ff <= csr_data[FW-2:0];
               pmp_pkg::CFG_FLAGS: flags_ff <= csr_data[1:0];
               pmp_pkg::CFG_VERTEX_BASE: vertex_base_ff <= csr_data;
               pmp_pkg::CFG_CELL_BASE: cell_base_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.count_inc) count_ff <= count_ff + 32'd1;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      unique case (cmd.mul_lane)
         3'd0, 3'd3: mul_b = normal_x_ff;
         3'd1, 3'd4: mul_b = normal_y_ff;
         3'd2, 3'd5: mul_b = normal_z_ff;
         default: mul_b = '0;
      endcase
      case (cmd.mul_src)
         pmp_pkg::SRC_POINT: begin
            case (cmd.mul_lane)
               3'd0: mul_a = pmp_pkg::OPND_W'(item_ff.point_x);
               3'd1: mul_a = pmp_pkg::OPND_W'(item_ff.point_y);
               3'd2: mul_a = pmp_pkg::OPND_W'(item_ff.point_z);
               default: mul_a = '0;
            endcase
         end
         pmp_pkg::SRC_VEC: begin
            case (cmd.mul_lane)
               3'd0: mul_a = pmp_pkg::OPND_W'(item_ff.field_vec_x);
               3'd1: mul_a = pmp_pkg::OPND_W'(item_ff.field_vec_y);
               3'd2: mul_a = pmp_pkg::OPND_W'(item_ff.field_vec_z);
               default: mul_a = '0;
            endcase
         end
         pmp_pkg::SRC_CORR: mul_a = (cmd.mul_lane < 3'd3) ? kp_ff : kv_ff;
         default: mul_a = '0;
      endcase
      // Correction terms carry their rounding half into the product.
      rnd = (cmd.mul_src == pmp_pkg::SRC_CORR) ? pmp_pkg::PROD_W'(66'sd268435456) : '0;
   end

   assign prod_in = mul_a * mul_b + rnd;

   // Dot products accumulate from a rounding half at bit 29.
   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = pmp_pkg::ACC_W'(67'sd536870912);
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + pmp_pkg::ACC_W'(prod_ff);
      end
   end

   assign acc_q16 = $signed(acc_ff[pmp_pkg::ACC_W-1:30]);
   assign raw_in = acc_q16 + pmp_pkg::DIST_W'(plane_offset_ff);

   // Mirror decision on the signed distance against the margin.
   assign raw_ext = pmp_pkg::DIFF_W'(raw_ff);
   assign margin_ext = $signed({7'd0, margin_ff});
   assign judge_sum = raw_ext + margin_ext;
   assign judge_diff = raw_ext - margin_ext;
   assign normal_zero = (normal_x_ff == '0) && (normal_y_ff == '0) && (normal_z_ff == '0);
   always_comb begin
      if (flags_ff[pmp_pkg::FLAG_INSIDE_OUT]) begin
         beyond = judge_sum[pmp_pkg::DIFF_W-1];
      end else begin
         beyond = !judge_diff[pmp_pkg::DIFF_W-1] && (judge_diff != '0);
      end
      status.mirror_ok = !normal_zero && (flags_ff[pmp_pkg::FLAG_FORCE] || beyond);
   end

   // Subtract the rounded correction term from the coordinate and saturate.
   always_comb begin
      case (cmd.res_lane)
         3'd0: q_sel = item_ff.point_x;
         3'd1: q_sel = item_ff.point_y;
         3'd2: q_sel = item_ff.point_z;
         3'd3: q_sel = item_ff.field_vec_x;
         3'd4: q_sel = item_ff.field_vec_y;
         3'd5: q_sel = item_ff.field_vec_z;
         default: q_sel = '0;
      endcase
      diff = pmp_pkg::DIFF_W'(q_sel)
             - pmp_pkg::DIFF_W'($signed(prod_ff[pmp_pkg::PROD_W-1:29]));
      res_val = pmp_pkg::sat32(diff);
   end

   // Item, product, accumulator and result registers.
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_payload;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      if (cmd.raw_save) raw_ff <= raw_in;
      if (cmd.kp_save) kp_ff <= pmp_pkg::clamp33(raw_ff);
      if (cmd.kv_save) kv_ff <= pmp_pkg::clamp33(acc_q16);
      if (cmd.res_wr) begin
         case (cmd.res_lane)
            3'd0: begin
               res_ff.mirror_x <= res_val;
               res_ff.mirror_scalar <= item_ff.field_scalar;
               res_ff.new_vertex_label <= vertex_base_ff + count_ff;
               res_ff.new_cell_label <= cell_base_ff + count_ff;
            end
            3'd1: res_ff.mirror_y <= res_val;
            3'd2: res_ff.mirror_z <= res_val;
            3'd3: res_ff.mirror_vec_x <= res_val;
            3'd4: res_ff.mirror_vec_y <= res_val;
            3'd5: res_ff.mirror_vec_z <= res_val;
            default: ;
         endcase
      end
   end

   assign rsp_payload = res_ff;

endmodule

/* design/plane_mirror_points.sv */
// Reflects one cloud point and its attached vector across the configured plane
// n.x + d = 0 and hands out fresh vertex and cell labels for each mirrored item.
// Items are worked one at a time through a single shared 34 by 32 bit multiplier,
// so the multiplies of the two dot products and the six correction terms run one
// after another. A mirrored item occupies the block until rsp_stall lets its
// result go; a dropped one (zero normal, or distance not beyond the margin
// without force) only until the judge state, and gives no result. The next item
// is taken in the idle cycle that follows, so no new item is taken before the
// last is through. req_stall is high whenever an item is in flight.
// Configuration is to be written by the user through csr_write_enable, csr_index
// and csr_data only while the block is idle; the block itself does not enforce
// this. mirror_flags resets to force and all else to zero.
module plane_mirror_points (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  pmp_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output pmp_pkg::rsp_type rsp_payload,
   input  logic csr_write_enable,
   input  logic [pmp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pmp_pkg::FIELD_W-1:0] csr_data
);

   pmp_pkg::cmd_type cmd;
   pmp_pkg::status_type status;

   // Sequencer for the multiply steps and the handshakes.
   pmp_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status(status),
      .cmd(cmd)
   );

   // Registers, multiplier, accumulator and result assembly.
   pmp_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_payload(req_payload),
      .rsp_payload(rsp_payload),
      .cmd(cmd),
      .status(status)
   );

endmodule

/* verif/plane_mirror_checker.sv */
module plane_mirror_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  pmp_pkg::req_type req_payload,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  pmp_pkg::rsp_type rsp_payload,
   input  logic csr_write_enable,
   input  logic [pmp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pmp_pkg::FIELD_W-1:0] csr_data,
   output int unsigned fault_count,
   output int unsigned mirrors_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Largest distance or projection that may scale the normal, Q16.16.
   localparam logic signed [36:0] REACH_MAX = 37'sh1_FFFF_FFFF;
   localparam int unsigned REPORT_LIMIT = 10;

   // Shadow copy of the plane registers and the label counter.
   logic signed [31:0] normal_x, normal_y, normal_z, plane_offset;
   logic [30:0] on_plane_margin;
   logic [1:0] mirror_flags;
   logic [31:0] vertex_label_base, cell_label_base, mirror_count;

   // Mirrored points that are owed by the block, oldest first.
   pmp_pkg::rsp_type awaited_mirrors[$];
   pmp_pkg::rsp_type predicted, oldest;
   int unsigned results_seen;

   // Dot product of a Q16.16 triple with the normal, rounded back to Q16.16.
   function automatic logic signed [36:0] project_q16(input logic signed [31:0] a, b, c);
      logic signed [66:0] a_w, b_w, c_w, nx_w, ny_w, nz_w, acc;
      a_w = a;
      b_w = b;
      c_w = c;
      nx_w = normal_x;
      ny_w = normal_y;
      nz_w = normal_z;
      acc = a_w * nx_w + b_w * ny_w + c_w * nz_w + (67'sd1 <<< 29);
      return 37'(acc >>> 30);
   endfunction

   // One coordinate minus 2*k*n, with k clamped first and the result saturated.
   function automatic logic signed [31:0] reflect_q16(input logic signed [31:0] q,
                                                      input logic signed [36:0] k,
                                                      input logic signed [31:0] n);
      logic signed [36:0] kc;
      logic signed [65:0] k_w, n_w, prod;
      logic signed [37:0] q_w, term, diff;
      kc = k;
      if (k > REACH_MAX) begin
         kc = REACH_MAX;
      end else if (k < -REACH_MAX) begin
         kc = -REACH_MAX;
      end
      k_w = kc;
      n_w = n;
      prod = k_w * n_w + (66'sd1 <<< 28);
      term = 38'(prod >>> 29);
      q_w = q;
      diff = q_w - term;
      if (diff > 38'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (diff < -38'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return diff[31:0];
   endfunction

   // Decides whether a point is mirrored and, if so, what the block returns for it.
   function automatic bit mirror_due(input pmp_pkg::req_type p,
                                     output pmp_pkg::rsp_type m);
      logic signed [36:0] raw, side_dist, vproj;
      m = '0;
      if (normal_x == 0 && normal_y == 0 && normal_z == 0) begin
         return 1'b0;
      end
      raw = project_q16(p.point_x, p.point_y, p.point_z) + plane_offset;
      side_dist = mirror_flags[pmp_pkg::FLAG_INSIDE_OUT] ? -raw : raw;
      if (!(side_dist > $signed({6'd0, on_plane_margin}) ||
            mirror_flags[pmp_pkg::FLAG_FORCE])) begin
         return 1'b0;
      end
      vproj = project_q16(p.field_vec_x, p.field_vec_y, p.field_vec_z);
      m.mirror_x = reflect_q16(p.point_x, raw, normal_x);
      m.mirror_y = reflect_q16(p.point_y, raw, normal_y);
      m.mirror_z = reflect_q16(p.point_z, raw, normal_z);
      m.mirror_vec_x = reflect_q16(p.field_vec_x, vproj, normal_x);
      m.mirror_vec_y = reflect_q16(p.field_vec_y, vproj, normal_y);
      m.mirror_vec_z = reflect_q16(p.field_vec_z, vproj, normal_z);
      m.mirror_scalar = p.field_scalar;
      m.new_vertex_label = vertex_label_base + mirror_count;
      m.new_cell_label = cell_label_base + mirror_count;
      return 1'b1;
   endfunction

   task automatic note_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("%s", what);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         note_fault($sformatf("result %0d, %s: expected %h, got %h",
                              results_seen, name, want, got));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         normal_x = '0;
         normal_y = '0;
         normal_z = '0;
         plane_offset = '0;
         on_plane_margin = '0;
         mirror_flags = pmp_pkg::FLAGS_RESET;
         vertex_label_base = '0;
         cell_label_base = '0;
         mirror_count = '0;
         awaited_mirrors.delete();
      end else begin
         // Follow register writes; bits beyond a register's width are dropped.
         if (csr_write_enable) begin
            case (csr_index)
               pmp_pkg::CFG_NORMAL_X: normal_x = csr_data;
               pmp_pkg::CFG_NORMAL_Y: normal_y = csr_data;
               pmp_pkg::CFG_NORMAL_Z: normal_z = csr_data;
               pmp_pkg::CFG_PLANE_OFFSET: plane_offset = csr_data;
               pmp_pkg::CFG_MARGIN: on_plane_margin = csr_data[30:0];
               pmp_pkg::CFG_FLAGS: mirror_flags = csr_data[1:0];
               pmp_pkg::CFG_VERTEX_BASE: vertex_label_base = csr_data;
               pmp_pkg::CFG_CELL_BASE: cell_label_base = csr_data;
               default: ;
            endcase
         end

         // Each accepted point may owe one mirrored item.
         if (req_valid && !req_stall && mirror_due(req_payload, predicted)) begin
            awaited_mirrors = {awaited_mirrors, predicted};
            mirror_count = mirror_count + 1;
         end

         // Each returned item is matched against the oldest one owed.
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (awaited_mirrors.size() == 0) begin
               note_fault($sformatf("result %0d arrived with none owed: %h",
                                    results_seen, rsp_payload));
            end else begin
               oldest = awaited_mirrors.pop_front();
               check_field("mirror_x", oldest.mirror_x, rsp_payload.mirror_x);
               check_field("mirror_y", oldest.mirror_y, rsp_payload.mirror_y);
               check_field("mirror_z", oldest.mirror_z, rsp_payload.mirror_z);
               check_field("mirror_vec_x", oldest.mirror_vec_x, rsp_payload.mirror_vec_x);
               check_field("mirror_vec_y", oldest.mirror_vec_y, rsp_payload.mirror_vec_y);
               check_field("mirror_vec_z", oldest.mirror_vec_z, rsp_payload.mirror_vec_z);
               check_field("mirror_scalar", oldest.mirror_scalar, rsp_payload.mirror_scalar);
               check_field("new_vertex_label", oldest.new_vertex_label,
                           rsp_payload.new_vertex_label);
               check_field("new_cell_label", oldest.new_cell_label,
                           rsp_payload.new_cell_label);
            end
         end
      end
      mirrors_pending <= awaited_mirrors.size();
   end

endmodule

/* verif/tb_plane_mirror_points.sv */
module tb_plane_mirror_points;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RUN_LIMIT = 300_000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_ITEMS = 48;

   // Handy Q2.30 and 32-bit values.
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] MINUS_ONE_Q30 = 32'hC000_0000;
   localparam logic [31:0] MAX_S32 = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN_S32 = 32'h8000_0000;
   localparam logic [31:0] FORCE_BIT = 32'd1 << pmp_pkg::FLAG_FORCE;
   localparam logic [31:0] INSIDE_OUT_BIT = 32'd1 << pmp_pkg::FLAG_INSIDE_OUT;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pmp_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pmp_pkg::rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [pmp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pmp_pkg::FIELD_W-1:0] csr_data = '0;

   int unsigned fault_count, mirrors_pending, cycle_count, burst_left;
   logic [1:0] stall_style = '0;
   logic [5:0] stall_phase = '0;

   plane_mirror_points i_dut (.*);

   plane_mirror_checker i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // The receiver changes its stall habit each time the 6-bit phase counter wraps.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase == '0) begin
         stall_style <= 2'($urandom_range(0, 3));
      end
      case (stall_style)
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= 1'($urandom_range(0, 1));
         2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_phase[2];
      endcase
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic pmp_pkg::req_type make_point(input logic [31:0] px, py, pz, vx, vy, vz,
                                                   scalar);
      return pmp_pkg::req_type'{px, py, pz, vx, vy, vz, scalar};
   endfunction

   // Mostly modest coordinates, with the extremes and full-range values mixed in.
   function automatic logic [31:0] random_coord();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         return MAX_S32;
      end else if (pick == 1) begin
         return MIN_S32;
      end else if (pick == 2) begin
         return '0;
      end else if (pick < 14) begin
         return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      end
      return $urandom();
   endfunction

   function automatic pmp_pkg::req_type random_point();
      return make_point(random_coord(), random_coord(), random_coord(),
                        random_coord(), random_coord(), random_coord(), $urandom());
   endfunction

   function automatic logic [31:0] random_normal();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ONE_Q30;
         2: return MINUS_ONE_Q30;
         default: return $urandom_range(0, 32'h8000_0000) - ONE_Q30;
      endcase
   endfunction

   // Offers one item and returns once an edge has passed and req_stall is low. Gaps
   // fall only between bursts, so valid stays high across a burst.
   task automatic send_point(input pmp_pkg::req_type point);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_payload <= point;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   // Holds back until every owed item is back and a dropped point has drained.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirrors_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all eight registers in index order.
   task automatic program_plane(input logic [31:0] nx, ny, nz, offset, margin, flags,
                                vbase, cbase);
      logic [31:0] values [8];
      pmp_pkg::cfg_index_type reg_index;
      values = '{nx, ny, nz, offset, margin, flags, vbase, cbase};
      reg_index = reg_index.first();
      do begin
         csr_write_enable <= 1'b1;
         csr_index <= reg_index;
         csr_data <= values[reg_index];
         @(posedge clock);
         reg_index = reg_index.next();
      end while (reg_index != reg_index.first());
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [31:0] margin_word;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Straight out of reset the normal is zero, so nothing is mirrored even
      // though force is set.
      send_point(make_point(MAX_S32, MAX_S32, MAX_S32, MAX_S32, MAX_S32, MAX_S32, MAX_S32));
      send_point(make_point(MIN_S32, MIN_S32, MIN_S32, MIN_S32, MIN_S32, MIN_S32, MIN_S32));
      settle();

      // Unit normal along x with force; junk above the flag bits, and label
      // bases whose cell label wraps on the second item and vertex label on the third.
      program_plane(ONE_Q30, '0, '0, '0, '0, FORCE_BIT | 32'hFFFF_FFFC,
                    32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_point(make_point(MAX_S32, MAX_S32, MAX_S32, MAX_S32, MAX_S32, MAX_S32, MAX_S32));
      send_point(make_point(MIN_S32, MIN_S32, MIN_S32, MIN_S32, MIN_S32, MIN_S32, MIN_S32));
      send_point(make_point('0, '0, '0, '0, '0, '0, '0));
      send_point(make_point(MIN_S32, MAX_S32, '0, MAX_S32, MIN_S32, '0, 32'h5555_AAAA));
      send_point(make_point(32'd1, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_8000, 32'd1,
                            32'hFFFF_FFFF, 32'hAAAA_5555));
      send_point(make_point(32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                            32'h3333_CCCC, 32'hCCCC_3333, 32'hFFFF_FFFF));
      settle();

      // Diagonal non-unit normal, lowest offset, inside-out with the widest
      // margin: the extreme distance, a point just past the margin and one
      // exactly on it.
      program_plane(ONE_Q30, ONE_Q30, ONE_Q30, MIN_S32, 32'hFFFF_FFFF, INSIDE_OUT_BIT,
                    '0, '0);
      send_point(make_point(MIN_S32, MIN_S32, MIN_S32, MIN_S32, MIN_S32, MIN_S32, '0));
      send_point(make_point('0, '0, '0, MAX_S32, MAX_S32, MAX_S32, 32'd7));
      send_point(make_point(32'd1, '0, '0, MIN_S32, MAX_S32, '0, 32'd8));
      send_point(make_point(32'hFFFF_FFFF, '0, '0, MAX_S32, MIN_S32, MAX_S32, 32'd9));
      settle();

      // Negative unit x with a tiny y component, so the dot product lands on
      // rounding ties; highest offset, zero margin, neither flag.
      program_plane(MINUS_ONE_Q30, 32'd1, '0, MAX_S32, 32'h8000_0000, 32'hFFFF_FFFC,
                    32'h0000_1000, 32'h8000_0000);
      send_point(make_point(MAX_S32, 32'h2000_0000, '0, 32'h0001_0000, '0, '0, 32'd1));
      send_point(make_point(MAX_S32, 32'hE000_0000, '0, '0, '0, '0, 32'd2));
      send_point(make_point(MAX_S32, 32'hDFFF_FFFF, '0, '0, '0, '0, 32'd3));
      send_point(make_point(MIN_S32, MIN_S32, MAX_S32, MIN_S32, MAX_S32, MIN_S32, 32'd4));

      // Random planes, each followed by a stream of random points.
      repeat (RANDOM_PHASES) begin
         settle();
         case ($urandom_range(0, 2))
            0: margin_word = $urandom();
            1: margin_word = $urandom_range(0, 32'h0010_0000);
            default: margin_word = $urandom() & 32'h8000_0000;
         endcase
         program_plane(random_normal(), random_normal(), random_normal(),
                       $urandom_range(0, 1) ? $urandom()
                                            : $urandom_range(0, 32'h0080_0000) - 32'h0040_0000,
                       margin_word, $urandom(),
                       $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 40),
                       $urandom());
         repeat (PHASE_ITEMS) send_point(random_point());
      end
      settle();

      if (fault_count == 0 && mirrors_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
